// File: rtl/core/cppf_pkg.sv
// Package for the coincident point pair finder: command, store entry and
// result types with their field widths. No dependencies.
package cppf_pkg;

    localparam int TAG_PATH_W  = 10;
    localparam int TAG_POINT_W = 16;
    localparam int COORD_W     = 24;
    localparam int TOL_W       = 23;
    localparam int SLOT_W      = 6;
    localparam int GAP_W       = 23;

    localparam logic [TOL_W-1:0] TOL_RESET = 23'd256;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = 2;

    typedef enum logic [1:0] {
        K_CLEAR  = 2'd0,
        K_APPEND = 2'd1,
        K_QUERY  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [TAG_PATH_W-1:0]   path;
        logic [TAG_POINT_W-1:0]  point;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic [SLOT_W-1:0]       slot;
    } t_cmd;

    typedef struct packed {
        logic [TAG_PATH_W-1:0]   path;
        logic [TAG_POINT_W-1:0]  point;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic [COORD_W-1:0]      cx;
        logic [COORD_W-1:0]      cy;
    } t_entry;

    typedef struct packed {
        logic                    found;
        logic [TAG_PATH_W-1:0]   first_path;
        logic [TAG_POINT_W-1:0]  first_point;
        logic [TAG_PATH_W-1:0]   second_path;
        logic [TAG_POINT_W-1:0]  second_point;
        logic [GAP_W-1:0]        gap;
        logic                    last;
    } t_result;

endpackage

// File: rtl/core/cppf_front.sv
// Front end: accepts input words, decodes the mode into a command (dropping words
// with an unknown mode) and holds it in a register for the queue. Depends on cppf_pkg.
module cppf_front
    import cppf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_mode,
    input  logic [TAG_PATH_W-1:0]  i_path_id,
    input  logic [TAG_POINT_W-1:0] i_point_id,
    input  logic [COORD_W-1:0]     i_x,
    input  logic [COORD_W-1:0]     i_y,
    input  logic [SLOT_W-1:0]      i_query_slot,
    output logic                   o_cmd_valid,
    output t_cmd                   o_cmd,
    input  logic                   i_cmd_ready
);

    logic r_v;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic n_keep;

    assign o_ready     = !r_v || i_cmd_ready;
    assign o_cmd_valid = r_v;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd.path  = i_path_id;
        n_cmd.point = i_point_id;
        n_cmd.x     = i_x;
        n_cmd.y     = i_y;
        n_cmd.slot  = i_query_slot;
        n_keep      = 1'b1;
        unique case (i_mode)
            MODE_CLEAR:  n_cmd.kind = K_CLEAR;
            MODE_APPEND: n_cmd.kind = K_APPEND;
            MODE_QUERY:  n_cmd.kind = K_QUERY;
            default: begin
                n_cmd.kind = K_CLEAR;
                n_keep     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: rtl/core/cppf_queue.sv
// Short command queue between front end and engine.
// Depends on cppf_pkg.
module cppf_queue
    import cppf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_data,
    input  logic i_pop
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] r_wp;
    logic [QUEUE_PW-1:0] r_rp;
    logic [QUEUE_PW:0]   r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_push_ready = r_cnt != (QUEUE_PW+1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_push_data;
    end

endmodule

// File: rtl/core/cppf_engine.sv
// Engine: point store, cell divider, nine-cell walk, shared multiplier,
// square root and result register. Depends on cppf_pkg.
module cppf_engine
    import cppf_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [TOL_W-1:0] i_tol,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_ready,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_ready
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DIVX  = 14'b00000000000010,
        S_DIVY  = 14'b00000000000100,
        S_WRITE = 14'b00000000001000,
        S_QRD   = 14'b00000000010000,
        S_QLAT  = 14'b00000000100000,
        S_LIM   = 14'b00000001000000,
        S_WALK  = 14'b00000010000000,
        S_MULX  = 14'b00000100000000,
        S_MULY  = 14'b00001000000000,
        S_CMP   = 14'b00010000000000,
        S_SQRT  = 14'b00100000000000,
        S_EMIT  = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    t_cmd          r_cmd;
    t_entry        r_mem [MAX_POINTS];
    t_entry        r_rd;
    t_entry        r_a;
    logic [IW-1:0] rd_addr;
    logic          we;

    logic [CW-1:0] r_j;
    logic [IW-1:0] r_rj;
    logic          r_rv;
    logic [1:0]    r_dx;
    logic [1:0]    r_dy;

    logic [23:0]   r_div;
    logic [23:0]   r_rem;
    logic [4:0]    r_it;
    logic          r_neg;
    logic [23:0]   r_cx;
    logic [23:0]   r_cy;

    logic [45:0]   r_lim;
    logic [23:0]   r_ax;
    logic [23:0]   r_ay;
    logic [47:0]   r_sqx;
    logic [47:0]   r_sqy;
    logic [45:0]   r_sn;
    logic [45:0]   r_sres;
    logic [45:0]   r_sbit;
    logic [TAG_PATH_W-1:0]  r_epath;
    logic [TAG_POINT_W-1:0] r_epoint;

    t_result       r_pend;
    logic          r_pv;
    t_result       r_out;
    t_result       n_out;
    logic          r_ov;
    logic          out_free;
    logic          emit_now;

    // divider step
    logic [23:0] dv_t;
    logic        dv_ge;
    logic [23:0] dv_rem;
    logic [23:0] dv_q;
    logic [24:0] dv_mag;
    logic [23:0] dv_cell;

    // walk check
    logic [25:0] kx;
    logic [25:0] ky;
    logic        cell_hit;
    logic        later;
    logic        cand;
    logic [24:0] ddx;
    logic [24:0] ddy;
    logic [24:0] adx;
    logic [24:0] ady;

    logic [23:0] mul_a;
    logic [47:0] prod;
    logic [48:0] d2;
    logic [45:0] sq_try;
    logic        sq_ge;
    logic [45:0] sq_res;

    function automatic logic [23:0] mag24(input logic [23:0] v);
        return v[23] ? (~v + 24'd1) : v;
    endfunction

    assign o_cmd_ready = r_state == S_IDLE;
    assign o_res_valid = r_ov;
    assign o_res       = r_out;
    assign out_free    = !r_ov || i_res_ready;
    assign emit_now    = out_free && ((r_state == S_EMIT && r_pv) || r_state == S_FIN);

    assign dv_t    = {r_rem[22:0], r_div[23]};
    assign dv_ge   = dv_t >= {1'b0, i_tol};
    assign dv_rem  = dv_ge ? dv_t - {1'b0, i_tol} : dv_t;
    assign dv_q    = {r_div[22:0], dv_ge};
    assign dv_mag  = {1'b0, dv_q} + {24'd0, (r_neg && dv_rem != '0)};
    assign dv_cell = r_neg ? 24'(~dv_mag + 25'd1) : dv_q;

    assign kx = {{2{r_a.cx[23]}}, r_a.cx} + {24'd0, r_dx} - 26'd1;
    assign ky = {{2{r_a.cy[23]}}, r_a.cy} + {24'd0, r_dy} - 26'd1;
    assign cell_hit = ({{2{r_rd.cx[23]}}, r_rd.cx} == kx)
                   && ({{2{r_rd.cy[23]}}, r_rd.cy} == ky);
    assign later = (r_rd.path > r_a.path)
                || (r_rd.path == r_a.path && r_rd.point > r_a.point);
    assign cand  = r_rv && cell_hit && later;
    assign ddx   = {r_rd.x[23], r_rd.x} - {r_a.x[23], r_a.x};
    assign ddy   = {r_rd.y[23], r_rd.y} - {r_a.y[23], r_a.y};
    assign adx   = ddx[24] ? (~ddx + 25'd1) : ddx;
    assign ady   = ddy[24] ? (~ddy + 25'd1) : ddy;

    always_comb begin
        priority if (r_state == S_LIM) mul_a = {1'b0, i_tol};
        else if (r_state == S_MULX)     mul_a = r_ax;
        else                            mul_a = r_ay;
    end
    assign prod = mul_a * mul_a;

    assign d2     = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign sq_try = r_sres + r_sbit;
    assign sq_ge  = r_sn >= sq_try;
    assign sq_res = sq_ge ? ((r_sres >> 1) + r_sbit) : (r_sres >> 1);

    // word leaving for the output register
    always_comb begin
        n_out = r_pend;
        if (r_state == S_FIN) begin
            if (r_pv) begin
                n_out.last = 1'b1;
            end else begin
                n_out             = '0;
                n_out.first_path  = r_a.path;
                n_out.first_point = r_a.point;
                n_out.last        = 1'b1;
            end
        end
    end

    assign rd_addr = (r_state == S_QRD) ? r_cmd.slot[IW-1:0] : r_j[IW-1:0];
    assign we      = r_state == S_WRITE;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_count[IW-1:0]] <= '{path: r_cmd.path, point: r_cmd.point,
                                        x: r_cmd.x, y: r_cmd.y,
                                        cx: r_cx, cy: r_cy};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (emit_now)         r_ov <= 1'b1;
            else if (i_res_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.kind)
                            K_CLEAR: r_count <= '0;
                            K_APPEND: begin
                                r_div <= mag24(i_cmd.x);
                                r_neg <= i_cmd.x[23];
                                r_rem <= '0;
                                r_it  <= '0;
                                r_cx  <= '0;
                                r_cy  <= '0;
                                if (r_count != CW'(MAX_POINTS)) begin
                                    r_state <= (i_tol == '0) ? S_WRITE : S_DIVX;
                                end
                            end
                            K_QUERY: begin
                                r_pv <= 1'b0;
                                if (7'(i_cmd.slot) >= 7'(r_count)) begin
                                    r_a     <= '0;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_QRD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIVX: begin
                    if (r_it == 5'd23) begin
                        r_cx    <= dv_cell;
                        r_div   <= mag24(r_cmd.y);
                        r_neg   <= r_cmd.y[23];
                        r_rem   <= '0;
                        r_it    <= '0;
                        r_state <= S_DIVY;
                    end else begin
                        r_div <= dv_q;
                        r_rem <= dv_rem;
                        r_it  <= r_it + 1'b1;
                    end
                end
                S_DIVY: begin
                    r_div <= dv_q;
                    r_rem <= dv_rem;
                    r_it  <= r_it + 1'b1;
                    if (r_it == 5'd23) begin
                        r_cy    <= dv_cell;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_IDLE;
                end
                S_QRD: r_state <= S_QLAT;
                S_QLAT: begin
                    r_a     <= r_rd;
                    r_state <= (i_tol == '0) ? S_FIN : S_LIM;
                end
                S_LIM: begin
                    r_lim   <= prod[45:0];
                    r_dx    <= '0;
                    r_dy    <= '0;
                    r_j     <= '0;
                    r_rv    <= 1'b0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (cand) begin
                        r_ax     <= adx[23:0];
                        r_ay     <= ady[23:0];
                        r_epath  <= r_rd.path;
                        r_epoint <= r_rd.point;
                        r_j      <= CW'(r_rj) + 1'b1;
                        r_rv     <= 1'b0;
                        r_state  <= S_MULX;
                    end else if (r_j < r_count) begin
                        r_rv <= 1'b1;
                        r_rj <= r_j[IW-1:0];
                        r_j  <= r_j + 1'b1;
                    end else begin
                        // cell pass done
                        r_rv <= 1'b0;
                        r_j  <= '0;
                        if (r_dy == 2'd2) begin
                            r_dy <= '0;
                            if (r_dx == 2'd2) r_state <= S_FIN;
                            else              r_dx <= r_dx + 1'b1;
                        end else begin
                            r_dy <= r_dy + 1'b1;
                        end
                    end
                end
                S_MULX: begin
                    r_sqx   <= prod;
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_sqy   <= prod;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_sn    <= d2[45:0];
                    r_sres  <= '0;
                    r_sbit  <= 46'd1 << 44;
                    r_state <= (d2 <= {3'b0, r_lim}) ? S_SQRT : S_WALK;
                end
                S_SQRT: begin
                    if (sq_ge) r_sn <= r_sn - sq_try;
                    r_sres <= sq_res;
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit[0]) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold one result back so the last one can be marked
                    if (!r_pv) begin
                        r_pend.found        <= 1'b1;
                        r_pend.first_path   <= r_a.path;
                        r_pend.first_point  <= r_a.point;
                        r_pend.second_path  <= r_epath;
                        r_pend.second_point <= r_epoint;
                        r_pend.gap          <= r_sres[GAP_W-1:0];
                        r_pend.last         <= 1'b0;
                        r_pv                <= 1'b1;
                        r_state             <= S_WALK;
                    end else if (out_free) begin
                        r_out               <= n_out;
                        r_pend.second_path  <= r_epath;
                        r_pend.second_point <= r_epoint;
                        r_pend.gap          <= r_sres[GAP_W-1:0];
                        r_state             <= S_WALK;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out   <= n_out;
                        r_pv    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_rv) |-> (CW'(r_rj) < r_count))
        else $error("walk read beyond stored points");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.found || r_out.last))
        else $error("empty result not marked last");

    a_pend_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == S_WALK || r_state == S_MULX || r_state == S_MULY
                  || r_state == S_CMP || r_state == S_SQRT || r_state == S_EMIT
                  || r_state == S_FIN))
        else $error("held result outside a query");

    a_fin_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (r_ov && r_out.last))
        else $error("query closed without final word");

endmodule

// File: rtl/core/coincident_point_pair_finder.sv
// Coincident point pair finder top level: tolerance register, front end,
// command queue and engine. Depends on cppf_pkg, cppf_front, cppf_queue, cppf_engine.
// Words are decoded by the front end and queued for the engine, which runs one
// command at a time. An append runs two 24-step cell divisions, skipped with
// zero tolerance. A query makes nine passes over the single store read port,
// plus the shared multiplier for each later point in a neighbour cell and a
// 23-step square root for each one within tolerance; with zero tolerance it
// skips the walk. Results wait in an output register.
module coincident_point_pair_finder
    import cppf_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [TOL_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_mode,
    input  logic [TAG_PATH_W-1:0]  i_path_id,
    input  logic [TAG_POINT_W-1:0] i_point_id,
    input  logic [COORD_W-1:0]     i_x,
    input  logic [COORD_W-1:0]     i_y,
    input  logic [SLOT_W-1:0]      i_query_slot,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_found,
    output logic [TAG_PATH_W-1:0]  o_first_path,
    output logic [TAG_POINT_W-1:0] o_first_point,
    output logic [TAG_PATH_W-1:0]  o_second_path,
    output logic [TAG_POINT_W-1:0] o_second_point,
    output logic [GAP_W-1:0]       o_gap,
    output logic                   o_last
);

    logic [TOL_W-1:0] r_tol;
    logic             f_v;
    t_cmd             f_cmd;
    logic             q_ready;
    logic             q_v;
    t_cmd             q_cmd;
    logic             e_ready;
    t_result          res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    cppf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_mode       (i_mode),
        .i_path_id    (i_path_id),
        .i_point_id   (i_point_id),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_query_slot (i_query_slot),
        .o_cmd_valid  (f_v),
        .o_cmd        (f_cmd),
        .i_cmd_ready  (q_ready)
    );

    cppf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f_v),
        .i_push_data  (f_cmd),
        .o_push_ready (q_ready),
        .o_pop_valid  (q_v),
        .o_pop_data   (q_cmd),
        .i_pop        (e_ready)
    );

    cppf_engine #(
        .MAX_POINTS (MAX_POINTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tol       (r_tol),
        .i_cmd_valid (q_v),
        .i_cmd       (q_cmd),
        .o_cmd_ready (e_ready),
        .o_res_valid (o_out_valid),
        .o_res       (res),
        .i_res_ready (i_out_ready)
    );

    assign o_found        = res.found;
    assign o_first_path   = res.first_path;
    assign o_first_point  = res.first_point;
    assign o_second_path  = res.second_path;
    assign o_second_point = res.second_point;
    assign o_gap          = res.gap;
    assign o_last         = res.last;

endmodule
